### hdl/rfca_pkg.sv
package rfca_pkg;

    // Frame limits.
    localparam int MAX_FRAME = 64;
    localparam int HEAD_LEN  = 4;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int HEAD_W    = $clog2(HEAD_LEN);

    // Addresses and frame types.
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
    localparam logic [7:0] NODE_ADDR_RST  = 8'hF3;
    localparam logic [7:0] TYPE_DATA      = 8'h44;
    localparam logic [7:0] TYPE_ACK       = 8'h41;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Verdict codes given with the result item.
    typedef enum logic [2:0] {
        V_NOT_ADDRESSED = 3'd0,
        V_DATA_OK       = 3'd1,
        V_BAD_CHECKSUM  = 3'd2,
        V_ACK_MATCHED   = 3'd3,
        V_IGNORED       = 3'd4,
        V_SHORT         = 3'd5,
        V_TOO_LONG      = 3'd6
    } t_verdict;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDR          = 2'd0,
        CFG_ACK_WAIT_MODE     = 2'd1,
        CFG_EXPECTED_PEER     = 2'd2,
        CFG_EXPECTED_CHECKSUM = 2'd3
    } t_cfg_idx;

    // Current configuration, as seen by the frame checker.
    typedef struct packed {
        logic [7:0] own_addr;
        logic       ack_wait_mode;
        logic [7:0] expected_peer;
        logic [7:0] expected_checksum;
    } t_cfg;

endpackage

### hdl/rfca_if.sv
// Received byte channel.
interface rfca_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// Verdict channel, one item per frame.
interface rfca_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] ack_to;
    logic [7:0] ack_from;
    logic [7:0] ack_check;

    modport source (output valid, output verdict, output ack_to, output ack_from,
                    output ack_check, input ready);
    modport sink   (input valid, input verdict, input ack_to, input ack_from,
                    input ack_check, output ready);
endinterface

// Configuration write channel.
interface rfca_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rfca_pkg::CFG_IDX_W-1:0]   index;
    logic [rfca_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/rf_frame_check_and_ack.sv
// Radio frame checker. Bytes of a received frame enter one per cycle on i_rx,
// the final byte marked by last_byte, and each frame gives exactly one verdict
// item on o_res, registered in the cycle after its final byte is taken. The
// block keeps a byte counter, the first four bytes and a running XOR from
// byte 2 on, so a new frame may start right after the final byte of the
// previous one. The input stalls only while a verdict sits in the output
// register and the downstream side is not ready. Frames longer than MAX_FRAME
// bytes are reported as too long, frames under four bytes as short. The ack
// fields are zero unless the verdict is data ok. Configuration is written
// through i_cfg and must only change between frames.
module rf_frame_check_and_ack (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfca_rx_if.sink    i_rx,
    rfca_res_if.source o_res,
    rfca_cfg_if.sink   i_cfg
);
    import rfca_pkg::*;

    t_cfg cfg;

    // Frame state.
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_running_xor, n_running_xor;
    logic             r_overflow, n_overflow;
    logic [7:0]       r_head [HEAD_LEN];

    // Output register.
    logic       r_out_valid;
    t_verdict   r_verdict, n_verdict;
    logic [7:0] r_ack_to, n_ack_to;
    logic [7:0] r_ack_from, n_ack_from;
    logic [7:0] r_ack_check, n_ack_check;

    logic       rx_take;
    logic [7:0] head0, head1, head2, head3;
    logic       at_limit;
    logic       addressed;

    rfca_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Accept a byte unless a verdict is held and the downstream side is not ready.
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign rx_take    = i_rx.valid && i_rx.ready;

    // Head bytes as they stand once the current byte is stored.
    assign head0 = (r_byte_count == CNT_W'(0)) ? i_rx.rx_byte : r_head[0];
    assign head1 = (r_byte_count == CNT_W'(1)) ? i_rx.rx_byte : r_head[1];
    assign head2 = (r_byte_count == CNT_W'(2)) ? i_rx.rx_byte : r_head[2];
    assign head3 = (r_byte_count == CNT_W'(3)) ? i_rx.rx_byte : r_head[3];

    assign at_limit  = r_byte_count >= CNT_W'(MAX_FRAME);
    assign addressed = (head0 == cfg.own_addr) || (head0 == BROADCAST_ADDR);

    // Next frame state: count saturates, XOR starts at byte 2.
    always_comb begin
        n_byte_count  = at_limit ? r_byte_count : r_byte_count + CNT_W'(1);
        n_running_xor = (r_byte_count >= CNT_W'(2)) ? (r_running_xor ^ i_rx.rx_byte)
                                                     : r_running_xor;
        n_overflow    = r_overflow || at_limit;
    end

    // Verdict for a frame ending with the current byte.
    always_comb begin
        n_verdict   = V_IGNORED;
        n_ack_to    = 8'h00;
        n_ack_from  = 8'h00;
        n_ack_check = 8'h00;
        if (n_overflow) begin
            n_verdict = V_TOO_LONG;
        end else if (r_byte_count < CNT_W'(HEAD_LEN - 1)) begin
            n_verdict = V_SHORT;
        end else if (!addressed) begin
            n_verdict = V_NOT_ADDRESSED;
        end else if (!cfg.ack_wait_mode) begin
            if (head1 != TYPE_DATA) begin
                n_verdict = V_IGNORED;
            end else if (i_rx.rx_byte == r_running_xor) begin
                n_verdict   = V_DATA_OK;
                n_ack_to    = head2;
                n_ack_from  = head0;
                n_ack_check = i_rx.rx_byte;
            end else begin
                n_verdict = V_BAD_CHECKSUM;
            end
        end else begin
            if (head1 != TYPE_ACK || head2 != cfg.expected_peer) begin
                n_verdict = V_IGNORED;
            end else if (head3 == cfg.expected_checksum) begin
                n_verdict = V_ACK_MATCHED;
            end else begin
                n_verdict = V_BAD_CHECKSUM;
            end
        end
    end

    // Frame state registers; everything returns to zero after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_running_xor <= 8'h00;
            r_overflow    <= 1'b0;
        end else if (rx_take) begin
            if (i_rx.last_byte) begin
                r_byte_count  <= '0;
                r_running_xor <= 8'h00;
                r_overflow    <= 1'b0;
            end else begin
                r_byte_count  <= n_byte_count;
                r_running_xor <= n_running_xor;
                r_overflow    <= n_overflow;
            end
        end
    end

    // Head byte store; entries are always written before a verdict reads them.
    always_ff @(posedge i_clk) begin
        if (rx_take && r_byte_count < CNT_W'(HEAD_LEN)) begin
            r_head[r_byte_count[HEAD_W-1:0]] <= i_rx.rx_byte;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rx_take && i_rx.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (rx_take && i_rx.last_byte) begin
            r_verdict   <= n_verdict;
            r_ack_to    <= n_ack_to;
            r_ack_from  <= n_ack_from;
            r_ack_check <= n_ack_check;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.verdict   = r_verdict;
    assign o_res.ack_to    = r_ack_to;
    assign o_res.ack_from  = r_ack_from;
    assign o_res.ack_check = r_ack_check;

    // A final byte always produces a verdict in the next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_take && i_rx.last_byte) |=> r_out_valid)
        else $error("final byte did not produce a verdict");

    // Ack fields are zero unless the frame was accepted as data.
    a_ack_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict != V_DATA_OK) |->
        (r_ack_to == 8'h00 && r_ack_from == 8'h00 && r_ack_check == 8'h00))
        else $error("ack fields set on a verdict other than data ok");

    // The byte counter saturates at the frame limit.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(MAX_FRAME))
        else $error("byte counter ran past the frame limit");

    // A held verdict blocks new bytes.
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !i_rx.ready)
        else $error("input accepted while the verdict was stalled");

endmodule

### hdl/rfca_cfg_regs.sv
module rfca_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rfca_cfg_if.sink      i_cfg,
    output rfca_pkg::t_cfg o_cfg
);
    import rfca_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Decode the register index; data is truncated to the register width.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_OWN_ADDR:          n_cfg.own_addr          = i_cfg.data;
                CFG_ACK_WAIT_MODE:     n_cfg.ack_wait_mode     = i_cfg.data[0];
                CFG_EXPECTED_PEER:     n_cfg.expected_peer     = i_cfg.data;
                CFG_EXPECTED_CHECKSUM: n_cfg.expected_checksum = i_cfg.data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_addr          <= NODE_ADDR_RST;
            r_cfg.ack_wait_mode     <= 1'b0;
            r_cfg.expected_peer     <= 8'h00;
            r_cfg.expected_checksum <= 8'h00;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
